/* hdl/mbe_pkg.sv */
// Shared types, constants and a helper function of the Mandelbrot escape counter.
package mbe_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned ITER_W  = 16;
  localparam int unsigned COUNT_W = 23;
  localparam int unsigned FIX_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // Depth of the queue between the front end and the iteration engine.
  localparam int unsigned QDEPTH = 2;

  // Register reset values.
  localparam logic [ITER_W-1:0]       RST_MAX_ITER    = 16'd2000;
  localparam logic signed [FIX_W-1:0] RST_REAL_ORIGIN = -32'sd134217721;
  localparam logic signed [FIX_W-1:0] RST_REAL_STEP   = 32'sd81920;
  localparam logic signed [FIX_W-1:0] RST_IMAG_ORIGIN = 32'sd7;
  localparam logic signed [FIX_W-1:0] RST_IMAG_STEP   = 32'sd36864;

  // Saturation limits of a fixed-point word and of the escaped-point count.
  localparam logic signed [FIX_W-1:0] FIX_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [FIX_W-1:0] FIX_MIN   = 32'sh8000_0000;
  localparam logic [COUNT_W-1:0]      COUNT_MAX = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ITER    = 3'd0,
    CFG_REAL_ORIGIN = 3'd1,
    CFG_REAL_STEP   = 3'd2,
    CFG_IMAG_ORIGIN = 3'd3,
    CFG_IMAG_STEP   = 3'd4
  } cfg_reg_t;

  // Input item.
  typedef struct packed {
    logic [IDX_W-1:0] col_index;
    logic [IDX_W-1:0] row_index;
    logic             clear_count;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic               escaped;
    logic [ITER_W-1:0]  iterations_used;
    logic [COUNT_W-1:0] escaped_total;
  } out_item_t;

  // Current configuration as seen by the front end and the engine.
  typedef struct packed {
    logic [ITER_W-1:0]       max_iterations;
    logic signed [FIX_W-1:0] real_origin;
    logic signed [FIX_W-1:0] real_step;
    logic signed [FIX_W-1:0] imag_origin;
    logic signed [FIX_W-1:0] imag_step;
  } cfg_t;

  // One point queued for iteration.
  typedef struct packed {
    logic signed [FIX_W-1:0] cr;
    logic signed [FIX_W-1:0] ci;
    logic                    clear_count;
  } point_t;

  // Queue status seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Front end states.
  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_PUSH
  } front_state_t;

  // Iteration engine states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_ADD,
    B_OUT
  } back_state_t;

  // Saturate a wide signed value to a 32-bit fixed-point word.
  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [63:0] v);
    logic upper_same;
    upper_same = (v[63:FIX_W-1] == '0) || (v[63:FIX_W-1] == '1);
    if (upper_same) begin
      return v[FIX_W-1:0];
    end else if (v[63]) begin
      return FIX_MIN;
    end else begin
      return FIX_MAX;
    end
  endfunction

endpackage

/* hdl/mbe_front.sv */
// Front end: takes a grid point, clamps its indexes and forms c for the queue.
module mbe_front #(
  parameter int unsigned GRID_POINTS = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mbe_pkg::in_item_t in_data,
  input  mbe_pkg::cfg_t     cfg,
  input  mbe_pkg::q_status_t q_status,
  output logic              q_push,
  output mbe_pkg::point_t   q_data
);
  import mbe_pkg::*;

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(GRID_POINTS - 1);

  front_state_t state_r, state_nxt;

  logic [IDX_W-1:0]        col_r, row_r;
  logic                    clr_r;
  logic signed [43:0]      rprod_r, iprod_r;
  logic [IDX_W-1:0]        col_clamped, row_clamped;
  logic                    accept;

  // Indexes beyond the grid are held at its last point.
  assign col_clamped = (in_data.col_index > IDX_MAX) ? IDX_MAX : in_data.col_index;
  assign row_clamped = (in_data.row_index > IDX_MAX) ? IDX_MAX : in_data.row_index;
  assign accept      = in_valid && !in_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    q_push    = 1'b0;
    case (state_r)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = F_MUL;
        end
      end
      F_MUL: begin
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_status.full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // Captured point and the step products.
  always_ff @(posedge clk) begin
    if (accept) begin
      col_r <= col_clamped;
      row_r <= row_clamped;
      clr_r <= in_data.clear_count;
    end
    if (state_r == F_MUL) begin
      rprod_r <= cfg.real_step * $signed({1'b0, col_r});
      iprod_r <= cfg.imag_step * $signed({1'b0, row_r});
    end
  end

  // Origin plus product, saturated to the fixed-point range.
  always_comb begin
    q_data.cr          = sat_fix(64'(cfg.real_origin) + 64'(rprod_r));
    q_data.ci          = sat_fix(64'(cfg.imag_origin) + 64'(iprod_r));
    q_data.clear_count = clr_r;
  end

endmodule

/* hdl/mbe_queue.sv */
// Short queue of points between the front end and the iteration engine.
module mbe_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mbe_pkg::point_t    push_data,
  input  logic               pop,
  output mbe_pkg::point_t    pop_data,
  output mbe_pkg::q_status_t status
);
  import mbe_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  point_t             entry_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign status.full  = (count_r == CNT_W'(QDEPTH));
  assign status.empty = (count_r == '0);
  assign pop_data     = entry_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full))
    else $error("point pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty))
    else $error("point popped from an empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill count lost a transfer");
`endif

endmodule

/* hdl/mbe_back.sv */
// Iteration engine: runs z = z*z + c for one point and keeps the escaped-point count.
module mbe_back #(
  parameter int unsigned FRACTION_BITS = 26
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mbe_pkg::cfg_t      cfg,
  input  mbe_pkg::q_status_t q_status,
  input  mbe_pkg::point_t    q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output mbe_pkg::out_item_t out_data
);
  import mbe_pkg::*;

  // Wide enough for a shifted product plus c at the smallest fraction width.
  localparam int unsigned SUM_W = 67 - FRACTION_BITS;
  localparam logic [63:0] BOUND = 64'd4 << (2 * FRACTION_BITS);

  back_state_t state_r, state_nxt;

  logic signed [FIX_W-1:0] zr_r, zi_r, cr_r, ci_r;
  logic                    clr_r;
  logic [ITER_W-1:0]       n_r;
  logic signed [63:0]      rr_r, ii_r, ri_r;
  logic                    esc_r;
  logic [ITER_W-1:0]       used_r;
  logic [COUNT_W-1:0]      count_r;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic [ITER_W-1:0]       limit;
  logic [63:0]             mag;
  logic                    escape_now;
  logic signed [SUM_W-1:0] nr_w, ni_w;
  logic signed [FIX_W-1:0] zr_new, zi_new;
  logic                    out_free;
  logic                    deliver;
  logic [COUNT_W-1:0]      count_base, count_new;

  // A limit of zero runs one iteration.
  assign limit = (cfg.max_iterations == '0) ? ITER_W'(1) : cfg.max_iterations;

  // Escape test on the squares of the current z; none before the first iteration.
  assign mag        = $unsigned(rr_r) + $unsigned(ii_r);
  assign escape_now = (n_r != '0) && (mag > BOUND);

  // Next z from the registered products, rounded toward minus infinity.
  always_comb begin
    nr_w   = SUM_W'(rr_r >>> FRACTION_BITS) - SUM_W'(ii_r >>> FRACTION_BITS) + SUM_W'(cr_r);
    ni_w   = SUM_W'(ri_r >>> (FRACTION_BITS - 1)) + SUM_W'(ci_r);
    zr_new = sat_fix(64'(nr_w));
    zi_new = sat_fix(64'(ni_w));
  end

  assign out_free = !out_valid_r || !out_stall;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, queue pop and result hand-off.
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    deliver   = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        state_nxt = B_ADD;
      end
      B_ADD: begin
        if (escape_now || (n_r == limit)) begin
          state_nxt = B_OUT;
        end else begin
          state_nxt = B_MUL;
        end
      end
      B_OUT: begin
        if (out_free) begin
          deliver   = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // Iteration datapath.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      zr_r  <= q_data.cr;
      zi_r  <= q_data.ci;
      cr_r  <= q_data.cr;
      ci_r  <= q_data.ci;
      clr_r <= q_data.clear_count;
      n_r   <= '0;
    end
    if (state_r == B_MUL) begin
      rr_r <= zr_r * zr_r;
      ii_r <= zi_r * zi_r;
      ri_r <= zr_r * zi_r;
    end
    if (state_r == B_ADD) begin
      if (escape_now) begin
        esc_r  <= 1'b1;
        used_r <= n_r;
      end else if (n_r == limit) begin
        esc_r  <= 1'b0;
        used_r <= limit;
      end else begin
        zr_r <= zr_new;
        zi_r <= zi_new;
        n_r  <= n_r + 1'b1;
      end
    end
  end

  // Running count: a clear comes first, then this point counts, saturating.
  assign count_base = clr_r ? '0 : count_r;
  assign count_new  = (esc_r && (count_base != COUNT_MAX)) ? count_base + 1'b1 : count_base;

  // Escaped-point count and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (deliver) begin
        count_r     <= count_new;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_data_r.escaped         <= esc_r;
      out_data_r.iterations_used <= used_r;
      out_data_r.escaped_total   <= count_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_ADD) |-> (n_r <= limit))
    else $error("iteration count ran past the limit");

  a_mul_then_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_MUL) |=> (state_r == B_ADD))
    else $error("products not followed by the update step");

  a_deliver_free: assert property (@(posedge clk) disable iff (!rst_n)
    deliver |-> (!out_valid_r || !out_stall))
    else $error("result overwrote one still waiting for transfer");
`endif

endmodule

/* hdl/mandelbrot_escape_counter.sv */
// Mandelbrot escape-time counter: one grid point in, escaped flag and counts out.
// Each accepted point (column, row) gives c = origin + step * index on each axis in
// signed fixed point and is iterated with z = z*z + c until |z|^2 exceeds four or the
// configured iteration limit is reached. The front end accepts a point, forms c and
// queues it, stalling its input until the point is queued; the iteration engine then
// runs a product step (the three 32 by 32 products) and an update step (add, saturate
// and escape test) per iteration. It holds a point from the pop through its passes to
// the hand-off to the output register, which waits out a stalled output, and pops no new
// point before that, so that loop sets the throughput. Results leave in order through an
// output register; the running count of escaped points saturates at its maximum and is
// cleared by reset or by a point that asks for it. Configuration is to be written only
// while no point is in flight; the block itself does not enforce it.
module mandelbrot_escape_counter #(
  parameter int unsigned GRID_POINTS   = 2048,
  parameter int unsigned FRACTION_BITS = 26
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  mbe_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output mbe_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mbe_pkg::FIX_W-1:0]        cfg_data
);
  import mbe_pkg::*;

  cfg_t      cfg_r;
  q_status_t q_status;
  logic      q_push, q_pop;
  point_t    q_push_data, q_pop_data;

  // Configuration registers; writes to unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_iterations <= RST_MAX_ITER;
      cfg_r.real_origin    <= RST_REAL_ORIGIN;
      cfg_r.real_step      <= RST_REAL_STEP;
      cfg_r.imag_origin    <= RST_IMAG_ORIGIN;
      cfg_r.imag_step      <= RST_IMAG_STEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_ITER:    cfg_r.max_iterations <= cfg_data[ITER_W-1:0];
        CFG_REAL_ORIGIN: cfg_r.real_origin    <= cfg_data;
        CFG_REAL_STEP:   cfg_r.real_step      <= cfg_data;
        CFG_IMAG_ORIGIN: cfg_r.imag_origin    <= cfg_data;
        CFG_IMAG_STEP:   cfg_r.imag_step      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Front end.
  mbe_front #(
    .GRID_POINTS (GRID_POINTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_status (q_status),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  // Point queue.
  mbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .status    (q_status)
  );

  // Iteration engine.
  mbe_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_status  (q_status),
    .q_data    (q_pop_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
